/* hw/rtl/olc_pkg.sv */
`default_nettype none
package olc_pkg;

  localparam int MAX_CLASSES = 4;
  localparam int DATA_W = 24;
  localparam int LOG_W = 29;
  localparam int LOG_STEPS = 24;
  localparam int LOG_LAT = LOG_STEPS + 1;
  localparam int EXP_STEPS = 24;
  localparam int DIV_STEPS = 24;
  localparam int DIV_LAT = DIV_STEPS + 1;
  localparam int CLASS_LAT = 2;
  localparam int ALIGN_LAT = DIV_LAT - CLASS_LAT;
  localparam int TOTAL_LAT = LOG_LAT + 2 + EXP_STEPS + 2 + DIV_LAT + 1;

  typedef enum logic [2:0] {
    CFG_ORIFICE_SIZE,
    CFG_SURFACE_AREA,
    CFG_BASE_PRESSURE,
    CFG_CLASS_COUNT,
    CFG_THRESHOLD_A,
    CFG_THRESHOLD_B,
    CFG_THRESHOLD_C,
    CFG_THRESHOLD_D
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ORIF_20MM,
    ORIF_30MM,
    ORIF_40MM,
    ORIF_60MM,
    ORIF_80MM,
    ORIF_100MM,
    ORIF_VENTURI
  } orifice_t;

  localparam logic [63:0] ONE_Q24 = 64'd1 << 24;
  localparam logic [63:0] K_40 = ((64'd99558 << 24) + 64'd50000) / 64'd100000;
  localparam logic [63:0] K_60 = ((64'd229643 << 24) + 64'd50000) / 64'd100000;
  localparam logic [63:0] K_80 = ((64'd426362 << 24) + 64'd50000) / 64'd100000;
  localparam logic [63:0] K_100 = ((64'd722534 << 24) + 64'd50000) / 64'd100000;
  localparam logic [63:0] N_40 = ((64'd49668 << 24) + 64'd50000) / 64'd100000;
  localparam logic [63:0] N_60 = ((64'd49539 << 24) + 64'd50000) / 64'd100000;
  localparam logic [63:0] N_80 = ((64'd49446 << 24) + 64'd50000) / 64'd100000;
  localparam logic [63:0] N_100 = ((64'd49325 << 24) + 64'd50000) / 64'd100000;
  localparam logic [63:0] CORR_EXP = ((64'd65 << 24) + 64'd50) / 64'd100;
  localparam logic [63:0] BIAS_40 = (ONE_Q24 - N_40) * (64'd8 << 24);
  localparam logic [63:0] BIAS_60 = (ONE_Q24 - N_60) * (64'd8 << 24);
  localparam logic [63:0] BIAS_80 = (ONE_Q24 - N_80) * (64'd8 << 24);
  localparam logic [63:0] BIAS_100 = (ONE_Q24 - N_100) * (64'd8 << 24);

  typedef struct packed {
    logic [27:0] k;
    logic [23:0] n;
    logic [55:0] bias;
  } coef_t;

  function automatic coef_t orifice_coef(input logic [2:0] size);
    coef_t c;
    c = '0;
    unique case (size)
      ORIF_40MM: c = '{k: K_40[27:0], n: N_40[23:0], bias: BIAS_40[55:0]};
      ORIF_60MM: c = '{k: K_60[27:0], n: N_60[23:0], bias: BIAS_60[55:0]};
      ORIF_80MM: c = '{k: K_80[27:0], n: N_80[23:0], bias: BIAS_80[55:0]};
      ORIF_100MM: c = '{k: K_100[27:0], n: N_100[23:0], bias: BIAS_100[55:0]};
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rv;
    logic [63:0] res;
    logic [63:0] bt;
    rv = v;
    res = '0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rv >= res + bt) begin
        rv = rv - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] exp_root(input int j);
    logic [63:0] r;
    r = 64'd1 << 32;
    for (int i = 1; i <= j; i++) begin
      r = isqrt64(r << 31);
    end
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/orifice_leakage_classifier_unit.sv */
`default_nettype none
// One sample pair is accepted in every clock cycle and busy is always low. Each result
// appears on done in order; the pipe is built around the 24-step log2 squaring chain,
// the 24-step exp2 root chain and the 24-step area divider, each one stage per bit.
// The receiver cannot stall, so nothing ever waits in the pipe.
module orifice_leakage_classifier_unit import olc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] diff_pressure,
  input  logic [DATA_W-1:0] static_pressure,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output logic              done,
  output logic [DATA_W-1:0] leakage,
  output logic [DATA_W-1:0] leakage_per_area,
  output logic [DATA_W-1:0] f700,
  output logic [2:0]        class_index,
  output logic              class_valid
);

  typedef struct packed {
    logic [5:0] ip_l;
    logic [5:0] ip_f;
    logic       lz;
    logic       en;
  } side_t;

  typedef struct packed {
    logic [DATA_W-1:0] leak;
    logic [DATA_W-1:0] f700;
    logic [2:0]        cls;
    logic              valid;
  } res_t;

  logic [2:0] orifice_size;
  logic [DATA_W-1:0] surface_area;
  logic [DATA_W-1:0] base_pressure;
  logic [2:0] class_count;
  logic [DATA_W-1:0] thresholds [0:MAX_CLASSES-1];
  logic [TOTAL_LAT-1:0] vld;

  logic [LOG_W-1:0] ld, ls, lb;
  logic [LOG_LAT-1:0] zd_pipe, zs_pipe;
  coef_t coef;

  logic [52:0] m1_nprod;
  logic signed [54:0] m1_fprod;
  logic m1_lz, m1_en;
  logic [55:0] m2_tl, m2_tf;
  logic m2_lz, m2_en;
  side_t side [0:EXP_STEPS];
  logic [31:0] pl, pf;

  logic [59:0] m3_prod;
  logic [31:0] m3_pf;
  side_t m3_side;
  logic [59:0] m4_shift;
  logic [DATA_W-1:0] m4_leak;
  logic [31:0] m4_pf;
  logic [5:0] m4_ip_f;
  logic m4_en;
  logic [55:0] m5_prod;
  logic [DATA_W-1:0] m5_leak;
  logic [5:0] m5_ip_f;
  logic m5_en;
  logic [55:0] m6_shift;
  logic [DATA_W-1:0] m6_leak, m6_f700;
  logic m6_en;
  logic [2:0] cnt, cls;
  logic run;
  res_t align [0:ALIGN_LAT];
  logic [DATA_W-1:0] area_eff, quot;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      orifice_size <= '0;
      surface_area <= '0;
      base_pressure <= '0;
      class_count <= '0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
        thresholds[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && !cfg_index[3]) begin
      unique case (cfg_reg_t'(cfg_index[2:0]))
        CFG_ORIFICE_SIZE: orifice_size <= cfg_data[2:0];
        CFG_SURFACE_AREA: surface_area <= cfg_data;
        CFG_BASE_PRESSURE: base_pressure <= cfg_data;
        CFG_CLASS_COUNT: class_count <= cfg_data[2:0];
        CFG_THRESHOLD_A: thresholds[0] <= cfg_data;
        CFG_THRESHOLD_B: thresholds[1] <= cfg_data;
        CFG_THRESHOLD_C: thresholds[2] <= cfg_data;
        CFG_THRESHOLD_D: thresholds[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL_LAT-2:0], start && !busy};
    end
  end

  assign done = vld[TOTAL_LAT-1];

  olc_log2 u_log_dp (.clk(clk), .x(diff_pressure), .y(ld));
  olc_log2 u_log_st (.clk(clk), .x(static_pressure), .y(ls));
  olc_log2 u_log_base (.clk(clk), .x(base_pressure), .y(lb));

  always_ff @(posedge clk) begin
    zd_pipe <= {zd_pipe[LOG_LAT-2:0], diff_pressure == '0};
    zs_pipe <= {zs_pipe[LOG_LAT-2:0], static_pressure == '0};
  end

  assign coef = orifice_coef(orifice_size);

  always_ff @(posedge clk) begin
    m1_nprod <= 53'(coef.n) * 53'(ld);
    m1_fprod <= 55'(signed'({1'b0, lb}) - signed'({1'b0, ls})) *
                55'(signed'({1'b0, CORR_EXP[23:0]}));
    m1_lz <= zd_pipe[LOG_LAT-1] || (coef.k == '0);
    m1_en <= (base_pressure != '0) && !zs_pipe[LOG_LAT-1];
    m2_tl <= 56'(m1_nprod) + coef.bias;
    m2_tf <= 56'(56'(m1_fprod) + (56'd32 << 48));
    m2_lz <= m1_lz;
    m2_en <= m1_en;
  end

  olc_exp2 u_exp_leak (.clk(clk), .f(m2_tl[47:24]), .p(pl));
  olc_exp2 u_exp_corr (.clk(clk), .f(m2_tf[47:24]), .p(pf));

  assign side[0] = '{ip_l: m2_tl[53:48], ip_f: m2_tf[53:48], lz: m2_lz, en: m2_en};

  for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_side
    always_ff @(posedge clk) begin
      side[k] <= side[k-1];
    end
  end

  assign m4_shift = m3_prod >> (6'd55 - m3_side.ip_l);
  assign m6_shift = m5_prod >> (6'd63 - m5_ip_f);

  always_ff @(posedge clk) begin
    m3_prod <= 60'(pl) * 60'(coef.k);
    m3_pf <= pf;
    m3_side <= side[EXP_STEPS];
    if (m3_side.lz) begin
      m4_leak <= '0;
    end else begin
      m4_leak <= (m4_shift > 60'(24'hFFFFFF)) ? '1 : m4_shift[DATA_W-1:0];
    end
    m4_pf <= m3_pf;
    m4_ip_f <= m3_side.ip_f;
    m4_en <= m3_side.en;
    m5_prod <= 56'(m4_leak) * 56'(m4_pf);
    m5_leak <= m4_leak;
    m5_ip_f <= m4_ip_f;
    m5_en <= m4_en;
    if (!m5_en) begin
      m6_f700 <= '0;
    end else begin
      m6_f700 <= (m6_shift > 56'(24'hFFFFFF)) ? '1 : m6_shift[DATA_W-1:0];
    end
    m6_leak <= m5_leak;
    m6_en <= m5_en;
  end

  always_comb begin
    cnt = (class_count > 3'(MAX_CLASSES)) ? 3'(MAX_CLASSES) : class_count;
    cls = '0;
    run = m6_en;
    for (int i = 0; i < MAX_CLASSES; i++) begin
      if (run && (3'(i) < cnt) && (m6_f700 >= thresholds[i])) begin
        cls = 3'(i + 1);
      end else begin
        run = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    align[0] <= '{leak: m6_leak, f700: m6_f700, cls: cls, valid: m6_en};
  end

  for (genvar k = 1; k <= ALIGN_LAT; k++) begin : g_align
    if (k < ALIGN_LAT) begin : g_mid
      always_ff @(posedge clk) begin
        align[k] <= align[k-1];
      end
    end else begin : g_last
      assign align[k] = align[k-1];
    end
  end

  assign area_eff = (surface_area == '0) ? 24'h010000 : surface_area;

  olc_div u_div (.clk(clk), .leak(m4_leak), .area(area_eff), .quot(quot));

  always_ff @(posedge clk) begin
    leakage <= align[ALIGN_LAT].leak;
    leakage_per_area <= quot;
    f700 <= align[ALIGN_LAT].f700;
    class_index <= align[ALIGN_LAT].cls;
    class_valid <= align[ALIGN_LAT].valid;
  end

endmodule
`default_nettype wire

/* hw/rtl/olc_log2.sv */
`default_nettype none
module olc_log2 import olc_pkg::*; (
  input  logic             clk,
  input  logic [DATA_W-1:0] x,
  output logic [LOG_W-1:0]  y
);

  logic [31:0] m_q [0:LOG_STEPS];
  logic [4:0] e_q [0:LOG_STEPS];
  logic [LOG_STEPS-1:0] frac_q [0:LOG_STEPS];
  logic [4:0] lead;
  logic [31:0] m0;

  always_comb begin
    lead = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (x[i]) begin
        lead = 5'(i);
      end
    end
    m0 = 32'(x) << (5'd31 - lead);
  end

  always_ff @(posedge clk) begin
    m_q[0] <= m0;
    e_q[0] <= lead;
    frac_q[0] <= '0;
  end

  for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_step
    logic [63:0] sq;
    logic [32:0] s;
    assign sq = 64'(m_q[k-1]) * 64'(m_q[k-1]);
    assign s = sq[63:31];
    always_ff @(posedge clk) begin
      m_q[k] <= s[32] ? s[32:1] : s[31:0];
      e_q[k] <= e_q[k-1];
      frac_q[k] <= {frac_q[k-1][LOG_STEPS-2:0], s[32]};
    end
  end

  assign y = {e_q[LOG_STEPS], frac_q[LOG_STEPS]};

endmodule
`default_nettype wire

/* hw/rtl/olc_exp2.sv */
`default_nettype none
module olc_exp2 import olc_pkg::*; (
  input  logic                 clk,
  input  logic [EXP_STEPS-1:0] f,
  output logic [31:0]          p
);

  logic [31:0] p_q [0:EXP_STEPS];
  logic [EXP_STEPS-1:0] f_q [0:EXP_STEPS];

  assign p_q[0] = 32'h8000_0000;
  assign f_q[0] = f;

  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_step
    localparam logic [31:0] ROOT = exp_root(k + 1);
    logic [63:0] prod;
    assign prod = 64'(p_q[k]) * 64'(ROOT);
    always_ff @(posedge clk) begin
      p_q[k+1] <= f_q[k][EXP_STEPS-1-k] ? prod[62:31] : p_q[k];
      f_q[k+1] <= f_q[k];
    end
  end

  assign p = p_q[EXP_STEPS];

endmodule
`default_nettype wire

/* hw/rtl/olc_div.sv */
`default_nettype none
module olc_div import olc_pkg::*; (
  input  logic              clk,
  input  logic [DATA_W-1:0] leak,
  input  logic [DATA_W-1:0] area,
  output logic [DATA_W-1:0] quot
);

  logic [DATA_W-1:0] rem_q [0:DIV_STEPS];
  logic [DATA_W-1:0] num_q [0:DIV_STEPS];
  logic [DATA_W-1:0] q_q [0:DIV_STEPS];
  logic sat_q [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    sat_q[0] <= 24'(leak[23:8]) >= area;
    rem_q[0] <= 24'(leak[23:8]);
    num_q[0] <= {leak[7:0], 16'd0};
    q_q[0] <= '0;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DATA_W:0] trial;
    logic take;
    assign trial = {rem_q[k-1], num_q[k-1][DATA_W-1]};
    assign take = trial >= {1'b0, area};
    always_ff @(posedge clk) begin
      rem_q[k] <= take ? 24'(trial - {1'b0, area}) : trial[DATA_W-1:0];
      num_q[k] <= {num_q[k-1][DATA_W-2:0], 1'b0};
      q_q[k] <= {q_q[k-1][DATA_W-2:0], take};
      sat_q[k] <= sat_q[k-1];
    end
  end

  assign quot = sat_q[DIV_STEPS] ? '1 : q_q[DIV_STEPS];

endmodule
`default_nettype wire
